>>> src/sgm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Sobel gradient magnitude block.
package sgm_pkg;

  localparam int PIXEL_W     = 8;
  localparam int GRAD_W      = 10;
  localparam int COL_OUT_W   = 10;
  localparam int ROW_W       = 12;
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int MAG_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd1024;
  localparam logic [FH_W-1:0] HEIGHT_LIMIT       = 13'd4096;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // One gradient job handed from the front to the back.
  typedef struct packed {
    logic [GRAD_W-1:0]    gx;
    logic [GRAD_W-1:0]    gy;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } grad_t;

endpackage

>>> src/sgm_front.sv
`timescale 1ns / 1ps
// Front end: pixel intake, line stores, 3x3 window and Sobel gradients.
module sgm_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sgm_pkg::FW_W-1:0]     frame_width,
  input  logic [sgm_pkg::FH_W-1:0]     frame_height,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sgm_pkg::PIXEL_W-1:0]  pixel,
  output logic                         push_valid,
  input  logic                         push_ready,
  output sgm_pkg::grad_t               push_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [13:0]   MAXW       = 14'(MAX_WIDTH);
  localparam logic [CW-1:0] LAST_ADDR  = CW'(MAX_WIDTH - 1);

  logic [sgm_pkg::PIXEL_W-1:0] line_a [MAX_WIDTH];
  logic [sgm_pkg::PIXEL_W-1:0] line_b [MAX_WIDTH];
  logic [sgm_pkg::PIXEL_W-1:0] win [9];

  logic                        clearing;
  logic [CW-1:0]               clr_addr;
  logic [CW-1:0]               col_count;
  logic [sgm_pkg::ROW_W-1:0]   row_count;

  logic                        s1_valid;
  logic                        s1_emit;
  logic                        s1_last;
  logic [CW-1:0]               s1_addr;
  logic [sgm_pkg::PIXEL_W-1:0] s1_px;
  logic [sgm_pkg::COL_OUT_W-1:0] s1_col;
  logic [sgm_pkg::ROW_W-1:0]   s1_row;
  logic [sgm_pkg::PIXEL_W-1:0] top_rd;
  logic [sgm_pkg::PIXEL_W-1:0] mid_rd;

  logic        in_fire;
  logic        s1_retire;
  logic [13:0] w_eff;
  logic [12:0] h_eff;
  logic [13:0] c14;
  logic [12:0] r13;
  logic        row_end;
  logic        frame_end;
  logic        emit;
  logic [13:0] col_m1;
  logic [12:0] row_m1;

  logic        mem_we;
  logic [CW-1:0] mem_addr;
  logic [sgm_pkg::PIXEL_W-1:0] wd_a;
  logic [sgm_pkg::PIXEL_W-1:0] wd_b;

  logic [11:0] gx_pos, gx_neg, gy_pos, gy_neg;

  // Clamp the frame size to what the stores can hold.
  always_comb begin
    if (14'(frame_width) < 14'd3) begin
      w_eff = 14'd3;
    end else if (14'(frame_width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = 14'(frame_width);
    end
    if (frame_height < 13'd3) begin
      h_eff = 13'd3;
    end else if (frame_height > sgm_pkg::HEIGHT_LIMIT) begin
      h_eff = sgm_pkg::HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height;
    end
  end

  always_comb begin
    c14       = 14'(col_count);
    r13       = 13'(row_count);
    row_end   = c14 >= w_eff - 14'd1;
    frame_end = row_end && (r13 >= h_eff - 13'd1);
    emit      = (c14 >= 14'd2) && (c14 <= w_eff - 14'd1) &&
                (r13 >= 13'd2) && (r13 <= h_eff - 13'd1);
    col_m1    = c14 - 14'd1;
    row_m1    = r13 - 13'd1;
  end

  assign s1_retire = s1_valid && (!s1_emit || push_ready);
  assign in_ready  = !clearing && (!s1_valid || s1_retire);
  assign in_fire   = in_valid && in_ready;

  // Position counters advance on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        col_count <= '0;
        row_count <= '0;
      end else if (row_end) begin
        col_count <= '0;
        row_count <= row_count + 12'd1;
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Clear both line stores after reset, one address a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_emit <= emit;
      s1_last <= frame_end;
      s1_addr <= col_count;
      s1_px   <= pixel;
      s1_col  <= col_m1[sgm_pkg::COL_OUT_W-1:0];
      s1_row  <= row_m1[sgm_pkg::ROW_W-1:0];
    end
  end

  assign mem_we   = clearing || s1_retire;
  assign mem_addr = clearing ? clr_addr : s1_addr;
  assign wd_a     = clearing ? '0 : s1_px;
  assign wd_b     = clearing ? '0 : mid_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_a[mem_addr] <= wd_a;
    end
    if (in_fire) begin
      mid_rd <= line_a[col_count];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_b[mem_addr] <= wd_b;
    end
    if (in_fire) begin
      top_rd <= line_b[col_count];
    end
  end

  // Shift the window one column as the beat leaves the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_retire) begin
      for (int k = 0; k < 3; k++) begin
        win[k*3+0] <= win[k*3+1];
        win[k*3+1] <= win[k*3+2];
      end
      win[2] <= top_rd;
      win[5] <= mid_rd;
      win[8] <= s1_px;
    end
  end

  // Gradients over the shifted window: old columns 1 and 2, new column.
  always_comb begin
    gx_pos = 12'(top_rd) + {3'd0, mid_rd, 1'b0} + 12'(s1_px);
    gx_neg = 12'(win[1]) + {3'd0, win[4], 1'b0} + 12'(win[7]);
    gy_pos = 12'(win[7]) + {3'd0, win[8], 1'b0} + 12'(s1_px);
    gy_neg = 12'(win[1]) + {3'd0, win[2], 1'b0} + 12'(top_rd);
  end

  always_comb begin
    push_valid     = s1_valid && s1_emit;
    push_data.gx   = (gx_pos >= gx_neg) ? 10'(gx_pos - gx_neg) : 10'(gx_neg - gx_pos);
    push_data.gy   = (gy_pos >= gy_neg) ? 10'(gy_pos - gy_neg) : 10'(gy_neg - gy_pos);
    push_data.col  = s1_col;
    push_data.row  = s1_row;
    push_data.last = s1_last;
  end

endmodule

>>> src/sgm_queue.sv
`timescale 1ns / 1ps
// Short queue of gradient jobs between the front and the back.
module sgm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  sgm_pkg::grad_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sgm_pkg::grad_t pop_data
);

  localparam int PW = $clog2(sgm_pkg::QUEUE_DEPTH);
  localparam logic [PW:0] FULL = (PW+1)'(sgm_pkg::QUEUE_DEPTH);

  sgm_pkg::grad_t slots [sgm_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

>>> src/sgm_back.sv
`timescale 1ns / 1ps
// Back end: sum of squares, bit-pair square root, saturation and output register.
module sgm_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  sgm_pkg::grad_t                 pop_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sgm_pkg::MAG_W-1:0]      magnitude,
  output logic [sgm_pkg::COL_OUT_W-1:0]  out_col,
  output logic [sgm_pkg::ROW_W-1:0]      out_row,
  output logic                           frame_last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQR  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_HOLD = 4'b1000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  sgm_pkg::grad_t job;
  logic [15:0]    rem;
  logic [15:0]    root;
  logic [15:0]    bitv;
  logic           sat;

  logic [19:0]    gx_sq;
  logic [19:0]    gy_sq;
  logic [20:0]    sum;
  logic [16:0]    trial;
  logic           take;
  logic           out_free;

  assign pop_ready = state == ST_IDLE;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    gx_sq = 20'(job.gx) * 20'(job.gx);
    gy_sq = 20'(job.gy) * 20'(job.gy);
    sum   = 21'(gx_sq) + 21'(gy_sq);
    trial = 17'(root) + 17'(bitv);
    take  = 17'(rem) >= trial;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR:  state_next = ST_ROOT;
      ST_ROOT: begin
        if (bitv[0]) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          job <= pop_data;
        end
      end
      ST_SQR: begin
        rem  <= sum[15:0];
        sat  <= sum[20:16] != 5'd0;
        root <= '0;
        bitv <= 16'h4000;
      end
      ST_ROOT: begin
        if (take) begin
          rem  <= rem - trial[15:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      magnitude  <= sat ? 8'hFF : root[7:0];
      out_col    <= job.col;
      out_row    <= job.row;
      frame_last <= job.last;
    end
  end

endmodule

>>> src/sobel_gradient_magnitude.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Sobel gradient magnitude block.
//
// Pixels enter on in_valid/in_ready/pixel, one beat per pixel, raster order.
// Results leave on out_valid/out_ready with magnitude, out_col, out_row and
// frame_last; only interior pixels give a result, frame_last marks the last.
// Frame size comes from the write port (cfg_write, cfg_index, cfg_data):
// index 0 is frame_width, index 1 frame_height; write them only while idle.
// Sizes are clamped to 3..MAX_WIDTH columns and 3..4096 rows.
// The front takes one pixel per cycle while the job queue has room. The
// result for pixel (c,r) is formed once pixel (c+1,r+1) has arrived and
// passes through the front stage, the queue and the back (squaring, eight
// root steps one bit pair a cycle, output load).
// The back's square-root unit sets the sustained rate: it takes no new job
// until the result is loaded; border pixels pass through at one per cycle.
// After reset both line stores are zeroed, one address a cycle, over every
// address; in_ready stays low until that is done, config writes still go.
// A stalled receiver holds the output register; the queue then fills and
// in_ready drops until the back drains.
module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [sgm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgm_pkg::PIXEL_W-1:0]       pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgm_pkg::MAG_W-1:0]         magnitude,
  output logic [sgm_pkg::COL_OUT_W-1:0]     out_col,
  output logic [sgm_pkg::ROW_W-1:0]         out_row,
  output logic                              frame_last
);

  logic [sgm_pkg::FW_W-1:0] frame_width;
  logic [sgm_pkg::FH_W-1:0] frame_height;

  logic           push_valid;
  logic           push_ready;
  sgm_pkg::grad_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  sgm_pkg::grad_t pop_data;

  // Frame size registers; the write lands on the same edge, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sgm_pkg::FRAME_WIDTH_RESET;
      frame_height <= sgm_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sgm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sgm_pkg::FW_W-1:0];
        sgm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sgm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel        (pixel),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  sgm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sgm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .magnitude  (magnitude),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

endmodule
